[design/ssmd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssmd_pkg
// Shared types and constants for the single-source max delay block.
// ----------------------------------------------------------------------------
package ssmd_pkg;

  localparam int MAX_NODES   = 64;
  localparam int NODE_BITS   = $clog2(MAX_NODES);
  localparam int CNT_BITS    = 7;                     // node_count / node id field
  localparam int WEIGHT_BITS = 16;
  localparam int DIST_BITS   = 23;
  localparam int DELAY_BITS  = 22;
  localparam int ADDR_BITS   = 2 * NODE_BITS;
  localparam int EDGE_BITS   = WEIGHT_BITS + 1;       // present bit + weight
  localparam int EDGE_DEPTH  = MAX_NODES * MAX_NODES;
  localparam int CFG_IDX_BITS = 1;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_RUN   = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic [CFG_IDX_BITS-1:0] REG_NODE_COUNT = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SOURCE     = 1'b1;

  typedef struct packed {
    logic [DIST_BITS-1:0] path_len;
    logic                 reached;
    logic                 pending;
  } cell_t;

endpackage

[design/ssmd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssmd channel interfaces
// Command, result and register write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ssmd_cmd_if import ssmd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             op;
  logic [CNT_BITS-1:0]    from_node;
  logic [CNT_BITS-1:0]    to_node;
  logic [WEIGHT_BITS-1:0] weight;
  modport source (output valid, op, from_node, to_node, weight, input ready);
  modport sink   (input valid, op, from_node, to_node, weight, output ready);
endinterface

interface ssmd_res_if import ssmd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [DELAY_BITS-1:0] max_delay;
  logic                  all_reached;
  modport source (output valid, max_delay, all_reached, input ready);
  modport sink   (input valid, max_delay, all_reached, output ready);
endinterface

interface ssmd_cfg_if import ssmd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [CNT_BITS-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[design/ssmd_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssmd_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ssmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[design/ssmd_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssmd_cell
// One node slot of the distance ring; loads at run start, else shifts.
// ----------------------------------------------------------------------------
module ssmd_cell import ssmd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  load_en,
  input  logic  shift_en,
  input  cell_t load_val,
  input  cell_t shift_in,
  output cell_t q
);
  always_ff @(posedge clk) begin
    if (rst) begin
      q.reached  <= 1'b0;
      q.pending  <= 1'b0;
      q.path_len <= '0;
    end else if (load_en) begin
      q <= load_val;
    end else if (shift_en) begin
      q <= shift_in;
    end
  end
endmodule

[design/single_source_max_delay_core.sv]
`timescale 1ns / 1ps
// Operation: a clear pass writes every edge entry after accept; a load is written on accept.
// Run: a setup step loads the ring; for each pending node an idle search rotates
// the ring until that node reaches the head, a pick step captures it and a row scan
// relaxes its edges; then an empty search, a max sweep and a step to register the
// result. One command at a time. Reset: config returns to 1/1 and a pass clears
// every edge, during which no command is accepted.
// ----------------------------------------------------------------------------
// single_source_max_delay_core
// Edge store plus rotating ring of node cells doing shortest-path relaxation.
// ----------------------------------------------------------------------------
module single_source_max_delay_core import ssmd_pkg::*; (
  input logic       clk,
  input logic       rst,
  ssmd_cmd_if.sink  cmd,
  ssmd_res_if.source res,
  ssmd_cfg_if.sink  cfg
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CLEAR  = 7'b0000010,
    S_INIT   = 7'b0000100,
    S_SEEK   = 7'b0001000,
    S_ROW    = 7'b0010000,
    S_FINAL  = 7'b0100000,
    S_RESULT = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [CNT_BITS-1:0]  node_count;
  logic [CNT_BITS-1:0]  source_node;
  logic [CNT_BITS-1:0]  n_eff;
  logic [ADDR_BITS-1:0] clr_cnt;
  logic [NODE_BITS-1:0] cnt;
  logic [NODE_BITS-1:0] ph;       // node id currently at the head cell
  logic [NODE_BITS-1:0] u;
  logic [DIST_BITS-1:0] du;
  logic [DIST_BITS-1:0] best;
  logic                 all_ok;

  cell_t ring [MAX_NODES];
  cell_t head_next;
  logic  ring_load;
  logic  ring_shift;

  logic                  we;
  logic [ADDR_BITS-1:0]  waddr;
  logic [EDGE_BITS-1:0]  wdata;
  logic [ADDR_BITS-1:0]  raddr;
  logic [EDGE_BITS-1:0]  rdata;

  logic                  cmd_fire;
  logic                  load_ok;
  logic                  src_ok;
  logic [NODE_BITS-1:0]  src_idx;
  logic                  head_in;
  logic [DIST_BITS:0]    cand_sum;
  logic [DIST_BITS-1:0]  cand;

  assign cmd.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign cmd_fire  = cmd.valid && cmd.ready;

  always_comb begin
    if (node_count == '0) begin
      n_eff = CNT_BITS'(1);
    end else if (node_count > CNT_BITS'(MAX_NODES)) begin
      n_eff = CNT_BITS'(MAX_NODES);
    end else begin
      n_eff = node_count;
    end
  end

  assign src_ok  = (source_node != '0) && (source_node <= n_eff);
  assign src_idx = NODE_BITS'(source_node - CNT_BITS'(1));
  assign load_ok = (cmd.from_node != '0) && (cmd.from_node <= CNT_BITS'(MAX_NODES)) &&
                   (cmd.to_node != '0) && (cmd.to_node <= CNT_BITS'(MAX_NODES));

  // Edge store write side: clear pass or a single load.
  always_comb begin
    we    = 1'b0;
    waddr = clr_cnt;
    wdata = '0;
    if (state == S_CLEAR) begin
      we = 1'b1;
    end else if (cmd_fire && op_t'(cmd.op) == OP_LOAD && load_ok) begin
      we    = 1'b1;
      waddr = {NODE_BITS'(cmd.from_node - CNT_BITS'(1)), NODE_BITS'(cmd.to_node - CNT_BITS'(1))};
      wdata = {1'b1, cmd.weight};
    end
  end

  assign raddr = {(state == S_SEEK) ? ph : u, ph + NODE_BITS'(1)};

  ssmd_ram #(.WIDTH(EDGE_BITS), .DEPTH(EDGE_DEPTH)) u_edges (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Ring of node cells; the head's updated value wraps to the tail.
  assign ring_load  = (state == S_INIT);
  assign ring_shift = (state == S_SEEK) || (state == S_ROW) || (state == S_FINAL);
  assign head_in    = ({1'b0, ph} < n_eff);

  generate
    for (genvar k = 0; k < MAX_NODES; k++) begin : g_cell
      cell_t init_val;
      cell_t sh_in;
      assign init_val.path_len = '0;
      assign init_val.reached  = src_ok && (src_idx == NODE_BITS'(k));
      assign init_val.pending  = src_ok && (src_idx == NODE_BITS'(k));
      if (k == MAX_NODES - 1) begin : g_tail
        assign sh_in = head_next;
      end else begin : g_body
        assign sh_in = ring[k+1];
      end
      ssmd_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .load_en  (ring_load),
        .shift_en (ring_shift),
        .load_val (init_val),
        .shift_in (sh_in),
        .q        (ring[k])
      );
    end
  endgenerate

  // Relaxation of the edge u -> head node, saturating at the distance width.
  assign cand_sum = {1'b0, du} + (DIST_BITS+1)'(rdata[WEIGHT_BITS-1:0]);
  assign cand     = cand_sum[DIST_BITS] ? '1 : cand_sum[DIST_BITS-1:0];

  always_comb begin
    head_next = ring[0];
    if (state == S_SEEK) begin
      head_next.pending = 1'b0;
    end else if (state == S_ROW) begin
      if (rdata[WEIGHT_BITS] && head_in && (!ring[0].reached || cand < ring[0].path_len)) begin
        head_next.path_len = cand;
        head_next.reached  = 1'b1;
        head_next.pending  = 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_fire) begin
          unique case (op_t'(cmd.op))
            OP_CLEAR: state_next = S_CLEAR;
            OP_RUN:   state_next = S_INIT;
            OP_LOAD,
            OP_NONE:  state_next = S_IDLE;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_CLEAR:  if (clr_cnt == '1) state_next = S_IDLE;
      S_INIT:   state_next = S_SEEK;
      S_SEEK: begin
        if (ring[0].pending) begin
          state_next = S_ROW;
        end else if (cnt == '1) begin
          state_next = S_FINAL;
        end
      end
      S_ROW:    if (cnt == '1) state_next = S_SEEK;
      S_FINAL:  if (cnt == '1) state_next = S_RESULT;
      S_RESULT: if (!res.valid || res.ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_cnt     <= '0;
      cnt         <= '0;
      ph          <= '0;
      node_count  <= CNT_BITS'(1);
      source_node <= CNT_BITS'(1);
      res.valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          REG_NODE_COUNT: node_count  <= cfg.data;
          REG_SOURCE:     source_node <= cfg.data;
          default: ;
        endcase
      end
      if (state == S_RESULT && (!res.valid || res.ready)) begin
        res.valid <= 1'b1;
      end else if (res.valid && res.ready) begin
        res.valid <= 1'b0;
      end
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + ADDR_BITS'(1);
      end
      if (ring_shift) begin
        ph <= ph + NODE_BITS'(1);
      end
      unique case (state)
        S_INIT: begin
          ph  <= '0;
          cnt <= '0;
        end
        S_SEEK: begin
          cnt <= (ring[0].pending || cnt == '1) ? '0 : cnt + NODE_BITS'(1);
        end
        S_ROW, S_FINAL: cnt <= cnt + NODE_BITS'(1);
        default: ;
      endcase
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk) begin
    if (state == S_SEEK && ring[0].pending) begin
      du <= ring[0].path_len;
      u  <= ph;
    end
    if (state == S_SEEK) begin
      best   <= '0;
      all_ok <= 1'b1;
    end else if (state == S_FINAL && head_in) begin
      if (!ring[0].reached) begin
        all_ok <= 1'b0;
      end else if (ring[0].path_len > best) begin
        best <= ring[0].path_len;
      end
    end
    if (state == S_RESULT && (!res.valid || res.ready)) begin
      res.max_delay   <= all_ok ? best[DELAY_BITS-1:0] : '0;
      res.all_reached <= all_ok;
    end
  end

endmodule

[design/ssmd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssmd_checker
// Port-level checks for single_source_max_delay_core, attached by bind.
// ----------------------------------------------------------------------------
module ssmd_checker import ssmd_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  cmd_valid,
  input logic                  cmd_ready,
  input logic [1:0]            cmd_op,
  input logic                  res_valid,
  input logic                  res_ready,
  input logic [DELAY_BITS-1:0] res_max_delay,
  input logic                  res_all_reached
);

  // Result beat stays offered until taken.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result beat dropped before accept");

  // Edge clear pass after reset blocks commands.
  a_rst_busy: assert property (@(posedge clk)
    rst |=> !cmd_ready)
    else $error("command accepted during reset clear");

  // Unreached graph reports zero delay.
  a_unreached_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_all_reached |-> res_max_delay == '0)
    else $error("nonzero delay with unreached nodes");

  // Run and clear keep the block busy in the cycle after they are accepted.
  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && (cmd_op == OP_RUN || cmd_op == OP_CLEAR) |=> !cmd_ready)
    else $error("command accepted while run or clear in progress");

endmodule

bind single_source_max_delay_core ssmd_checker u_ssmd_checker (
  .clk             (clk),
  .rst             (rst),
  .cmd_valid       (cmd.valid),
  .cmd_ready       (cmd.ready),
  .cmd_op          (cmd.op),
  .res_valid       (res.valid),
  .res_ready       (res.ready),
  .res_max_delay   (res.max_delay),
  .res_all_reached (res.all_reached)
);
